// ===== design/xyp_pkg.sv =====
// Shared constants and register codes for the XY plotter trace capture block.
package xyp_pkg;

  // Register file
  localparam int unsigned CfgW      = 11;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;
  localparam logic        CfgPoints = 1'b0;
  localparam logic        CfgHeight = 1'b1;
  localparam logic [CfgW-1:0] PointsReset = 11'd1024;
  localparam logic [CfgW-1:0] HeightReset = 11'd1024;

  // Vertical scaling
  localparam int unsigned HeightW     = 11;
  localparam int unsigned HalfW       = HeightW - 1;
  localparam logic [HeightW-1:0] HeightLimit = 11'd1024;

  // Stored words
  localparam int unsigned TraceW  = 12;
  localparam int unsigned OffsetW = 11;

  // Calibration request and pass count
  localparam int unsigned CalibW = 4;

  // Bins below this value mark a return to the start of the sweep
  localparam int unsigned LowBinLimit = 5;

endpackage

// ===== design/xyp_scale.sv =====
// Scaling of one sample triple onto a horizontal bin, a display height and a pen state.
module xyp_scale #(
  parameter int unsigned MAX_POINTS  = 1024,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic [xyp_pkg::CfgW-1:0]    points_i,
  input  logic [xyp_pkg::CfgW-1:0]    height_i,
  input  logic [SAMPLE_BITS-1:0]      sample_x_i,
  input  logic [SAMPLE_BITS-1:0]      sample_y_i,
  input  logic [SAMPLE_BITS-1:0]      sample_pen_i,
  output logic [$clog2(MAX_POINTS)-1:0] bin_o,
  output logic [xyp_pkg::HeightW-1:0] y_o,
  output logic [xyp_pkg::HalfW-1:0]   half_o,
  output logic                        pen_down_o
);

  localparam int unsigned BinW = $clog2(MAX_POINTS);
  localparam int unsigned PW   = BinW + 1;
  localparam int unsigned CmpW = (PW > xyp_pkg::CfgW) ? PW : xyp_pkg::CfgW;
  localparam int unsigned XpW  = SAMPLE_BITS + PW;
  localparam int unsigned YpW  = SAMPLE_BITS + xyp_pkg::HeightW;

  logic [CmpW-1:0]              pts_ext;
  logic [PW-1:0]                p_eff;
  logic [PW-1:0]                p_last;
  logic [XpW-1:0]               x_prod;
  logic [PW-1:0]                bin_raw;
  logic [xyp_pkg::HeightW-1:0]  h_eff;
  logic [YpW-1:0]               y_prod;
  logic [xyp_pkg::HeightW-1:0]  y_raw;
  logic [xyp_pkg::HeightW-1:0]  y_sat;

  // Saturate the point count to the store depth, zero acts as one
  always_comb begin
    pts_ext = CmpW'(points_i);
    if (pts_ext > CmpW'(MAX_POINTS)) begin
      p_eff = PW'(MAX_POINTS);
    end else if (pts_ext == '0) begin
      p_eff = PW'(1);
    end else begin
      p_eff = pts_ext[PW-1:0];
    end
    p_last = p_eff - PW'(1);
  end

  // Scale x onto the bins and hold it below the point count
  always_comb begin
    x_prod  = XpW'(sample_x_i) * XpW'(p_eff);
    bin_raw = x_prod[XpW-1:SAMPLE_BITS];
    if (bin_raw > p_last) begin
      bin_o = p_last[BinW-1:0];
    end else begin
      bin_o = bin_raw[BinW-1:0];
    end
  end

  // Scale y to the display height and invert
  always_comb begin
    h_eff  = (height_i > xyp_pkg::HeightLimit) ? xyp_pkg::HeightLimit : height_i;
    y_prod = YpW'(h_eff) * YpW'(sample_y_i);
    y_raw  = y_prod[YpW-1:SAMPLE_BITS];
    y_sat  = (y_raw > h_eff) ? h_eff : y_raw;
    y_o    = h_eff - y_sat;
    half_o = h_eff[xyp_pkg::HeightW-1:1];
  end

  // Pen is down at or below mid-scale
  assign pen_down_o = (sample_pen_i <= {1'b1, {(SAMPLE_BITS-1){1'b0}}});

endmodule

// ===== design/xyp_store.sv =====
// Trace and offset memories with a clearing sweep after reset.
module xyp_store #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                re_i,
  input  logic [$clog2(MAX_POINTS)-1:0]       raddr_i,
  input  logic                                we_i,
  input  logic [$clog2(MAX_POINTS)-1:0]       waddr_i,
  input  logic signed [xyp_pkg::TraceW-1:0]   wtrace_i,
  input  logic signed [xyp_pkg::OffsetW-1:0]  woffset_i,
  output logic signed [xyp_pkg::TraceW-1:0]   rtrace_o,
  output logic signed [xyp_pkg::OffsetW-1:0]  roffset_o,
  output logic                                clearing_o
);

  localparam int unsigned BinW = $clog2(MAX_POINTS);

  logic signed [xyp_pkg::TraceW-1:0]  trace_mem  [MAX_POINTS];
  logic signed [xyp_pkg::OffsetW-1:0] offset_mem [MAX_POINTS];

  logic                               clear_q, clear_d;
  logic [BinW-1:0]                    clr_addr_q, clr_addr_d;
  logic signed [xyp_pkg::TraceW-1:0]  rtrace_q;
  logic signed [xyp_pkg::OffsetW-1:0] roffset_q;

  // Advance the sweep one entry a cycle until the last entry is zeroed
  always_comb begin
    clear_d    = clear_q;
    clr_addr_d = clr_addr_q;
    if (clear_q) begin
      clr_addr_d = clr_addr_q + BinW'(1);
      if (clr_addr_q == BinW'(MAX_POINTS - 1)) begin
        clear_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clear_q    <= clear_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Write port: sweep first, then the pipeline
  always_ff @(posedge clk_i) begin
    if (clear_q) begin
      trace_mem[clr_addr_q]  <= '0;
      offset_mem[clr_addr_q] <= '0;
    end else if (we_i) begin
      trace_mem[waddr_i]  <= wtrace_i;
      offset_mem[waddr_i] <= woffset_i;
    end
  end

  // Read port: hold the word until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rtrace_q  <= trace_mem[raddr_i];
      roffset_q <= offset_mem[raddr_i];
    end
  end

  assign rtrace_o   = rtrace_q;
  assign roffset_o  = roffset_q;
  assign clearing_o = clear_q;

endmodule

// ===== design/xy_plotter_trace_capture.sv =====
// Top level: register port, scaling stage, store read-modify-write and output register.
// Each accepted sample word is registered in stage A, then in stage B, then in the output register.
// Throughput: one word per cycle while the output is not stalled and no sweep runs; each memory takes one read
//   and one write a cycle, with the write of one word forwarded to the read of the next when both hit the same bin.
// Reset: control state clears at once; the memories are then swept to zero entry by entry,
//   with no sample word accepted; register writes are always taken.
module xy_plotter_trace_capture #(
  parameter int unsigned MAX_POINTS     = 1024,
  parameter int unsigned BUFFER_SAMPLES = 1024,
  parameter int unsigned SAMPLE_BITS    = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [xyp_pkg::PaddrW-1:0]         paddr,
  input  logic [xyp_pkg::PdataW-1:0]         pwdata,
  output logic [xyp_pkg::PdataW-1:0]         prdata,
  output logic                               pready,
  // sample words
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [SAMPLE_BITS-1:0]             sample_x_i,
  input  logic [SAMPLE_BITS-1:0]             sample_y_i,
  input  logic [SAMPLE_BITS-1:0]             sample_pen_i,
  input  logic [xyp_pkg::CalibW-1:0]         calib_request_i,
  // result words
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               plotted_o,
  output logic [$clog2(MAX_POINTS)-1:0]      bin_o,
  output logic signed [xyp_pkg::TraceW-1:0]  trace_value_o,
  output logic                               calibrating_o
);

  localparam int unsigned BinW   = $clog2(MAX_POINTS);
  localparam int unsigned PosW   = (BUFFER_SAMPLES > 1) ? $clog2(BUFFER_SAMPLES) : 1;
  localparam int unsigned TraceW  = xyp_pkg::TraceW;
  localparam int unsigned OffsetW = xyp_pkg::OffsetW;
  localparam int unsigned HeightW = xyp_pkg::HeightW;
  localparam int unsigned HalfW   = xyp_pkg::HalfW;
  localparam int unsigned CalibW  = xyp_pkg::CalibW;

  // Register file
  logic [xyp_pkg::CfgW-1:0] points_q, height_q;
  logic                     cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= xyp_pkg::PointsReset;
      height_q <= xyp_pkg::HeightReset;
    end else if (cfg_we) begin
      if (paddr[2] == xyp_pkg::CfgPoints) begin
        points_q <= pwdata[xyp_pkg::CfgW-1:0];
      end else begin
        height_q <= pwdata[xyp_pkg::CfgW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == xyp_pkg::CfgHeight) begin
      prdata = xyp_pkg::PdataW'(height_q);
    end else begin
      prdata = xyp_pkg::PdataW'(points_q);
    end
  end

  // Handshake chain
  logic clearing;
  logic in_accept;
  logic a_valid_q, a_move;
  logic b_valid_q, b_move;
  logic o_valid_q;

  assign b_move     = b_valid_q && (!o_valid_q || out_ready_i);
  assign a_move     = a_valid_q && (!b_valid_q || b_move);
  assign in_ready_o = !clearing && (!a_valid_q || a_move);
  assign in_accept  = in_valid_i && in_ready_o;

  // Scaling of the incoming word
  logic [BinW-1:0]    s_bin;
  logic [HeightW-1:0] s_y;
  logic [HalfW-1:0]   s_half;
  logic               s_pen;

  xyp_scale #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .points_i     (points_q),
    .height_i     (height_q),
    .sample_x_i   (sample_x_i),
    .sample_y_i   (sample_y_i),
    .sample_pen_i (sample_pen_i),
    .bin_o        (s_bin),
    .y_o          (s_y),
    .half_o       (s_half),
    .pen_down_o   (s_pen)
  );

  // Calibration pass count, in word order at acceptance
  logic [CalibW-1:0] calib_q, calib_d, calib_eff;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              s_calib;

  always_comb begin
    calib_eff = (calib_request_i != '0) ? calib_request_i : calib_q;
    s_calib   = (calib_eff != '0);
    calib_d   = calib_eff;
    pos_d     = pos_q + PosW'(1);
    if (pos_q == PosW'(BUFFER_SAMPLES - 1)) begin
      pos_d = '0;
      if (calib_eff != '0) begin
        calib_d = calib_eff - CalibW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q <= '0;
      pos_q   <= '0;
    end else if (in_accept) begin
      calib_q <= calib_d;
      pos_q   <= pos_d;
    end
  end

  // Stage A: scaled word, issues the store read
  logic               a_valid_d;
  logic [BinW-1:0]    a_bin_q;
  logic [HeightW-1:0] a_y_q;
  logic [HalfW-1:0]   a_half_q;
  logic               a_pen_q, a_calib_q;

  assign a_valid_d = in_accept || (a_valid_q && !a_move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_bin_q   <= s_bin;
      a_y_q     <= s_y;
      a_half_q  <= s_half;
      a_pen_q   <= s_pen;
      a_calib_q <= s_calib;
    end
  end

  // Plot decision against the last plotted bin
  logic [BinW-1:0] last_bin_q, last_bin_d, last_eff;
  logic            a_plot;

  always_comb begin
    last_eff   = (a_bin_q < BinW'(xyp_pkg::LowBinLimit)) ? '0 : last_bin_q;
    a_plot     = a_pen_q && (a_bin_q > last_eff);
    last_bin_d = a_plot ? a_bin_q : last_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_bin_q <= '0;
    end else if (a_move) begin
      last_bin_q <= last_bin_d;
    end
  end

  // Stores
  logic                      mem_we;
  logic signed [TraceW-1:0]  rd_trace;
  logic signed [OffsetW-1:0] rd_offset;
  logic signed [TraceW-1:0]  new_trace;
  logic signed [OffsetW-1:0] new_offset;
  logic [BinW-1:0]           b_bin_q;

  xyp_store #(
    .MAX_POINTS (MAX_POINTS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .re_i       (a_move),
    .raddr_i    (a_bin_q),
    .we_i       (mem_we),
    .waddr_i    (b_bin_q),
    .wtrace_i   (new_trace),
    .woffset_i  (new_offset),
    .rtrace_o   (rd_trace),
    .roffset_o  (rd_offset),
    .clearing_o (clearing)
  );

  // Stage B: read data back, modify and write
  logic               b_valid_d;
  logic [HeightW-1:0] b_y_q;
  logic [HalfW-1:0]   b_half_q;
  logic               b_plot_q, b_calib_q;
  logic               fwd_q, fwd_d;
  logic signed [TraceW-1:0]  fwd_trace_q;
  logic signed [OffsetW-1:0] fwd_offset_q;
  logic signed [TraceW-1:0]  cur_trace;
  logic signed [OffsetW-1:0] cur_offset;
  logic [TraceW-1:0]         cal_offset;

  assign b_valid_d = a_move || (b_valid_q && !b_move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      if (a_move) begin
        fwd_q <= fwd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_bin_q      <= a_bin_q;
      b_y_q        <= a_y_q;
      b_half_q     <= a_half_q;
      b_plot_q     <= a_plot;
      b_calib_q    <= a_calib_q;
      fwd_trace_q  <= new_trace;
      fwd_offset_q <= new_offset;
    end
  end

  // Forward a write that lands in the cycle of the next read to the same bin
  assign fwd_d = mem_we && (b_bin_q == a_bin_q);

  always_comb begin
    cur_trace  = fwd_q ? fwd_trace_q : rd_trace;
    cur_offset = fwd_q ? fwd_offset_q : rd_offset;
    cal_offset = TraceW'({2'b00, b_half_q}) - TraceW'({1'b0, b_y_q});
    new_offset = (b_plot_q && b_calib_q) ? signed'(cal_offset[OffsetW-1:0]) : cur_offset;
    if (b_plot_q) begin
      new_trace = signed'(TraceW'({1'b0, b_y_q}))
                + {{(TraceW-OffsetW){new_offset[OffsetW-1]}}, new_offset};
    end else begin
      new_trace = cur_trace;
    end
  end

  assign mem_we = b_move && b_plot_q;

  // Output register
  logic o_valid_d;

  assign o_valid_d = b_move || (o_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_move) begin
      plotted_o     <= b_plot_q;
      bin_o         <= b_bin_q;
      trace_value_o <= new_trace;
      calibrating_o <= b_calib_q;
    end
  end

  assign out_valid_o = o_valid_q;

`ifndef ASSERT_OFF
  // No word enters while the memories are being swept
  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing |-> !in_ready_o)
    else $error("sample word accepted during memory sweep");

  // A forwarded read follows a write to the same bin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_q) |-> $past(mem_we && (b_bin_q == a_bin_q)))
    else $error("forwarding without a matching write");

  // The pipeline never writes while the sweep owns the write port
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_we |-> !clearing)
    else $error("store write during memory sweep");

  // A stalled stage B holds its place until the output register frees
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && o_valid_q && !out_ready_i |=> b_valid_q)
    else $error("stage B word lost under stall");
`endif

endmodule
